FILE: sv/rlsd_pkg.sv
// Shared constants and types for the run-length scanline decoder.
`timescale 1ns / 1ps

package rlsd_pkg;

  localparam int unsigned DEF_MAX_LINE_WIDTH = 4096;
  localparam int unsigned DEF_MAX_CHANNELS   = 8;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIXEL_W     = 64;
  localparam int unsigned LANES       = PIXEL_W / BYTE_W;
  localparam int unsigned RUN_W       = 9;
  localparam int unsigned START_COL_W = 12;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned NCH_W       = 4;
  localparam int unsigned LWID_W      = 13;

  localparam logic [NCH_W-1:0]  RST_CHANNELS = NCH_W'(3);
  localparam logic [LWID_W-1:0] RST_WIDTH    = LWID_W'(512);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_WIDTH    = 2'd2
  } cfg_idx_e;

endpackage

FILE: sv/run_length_scanline_decoder.sv
// Run-length scanline decoder: byte stream in, packed pixel runs out.
//
// Usage: the input channel (in_valid_i/in_ready_o) takes one stream byte per
// item, with stream_end_i marking the end of data. In run-coded mode each
// pixel is a count byte (run = byte + 1) then channel_count channel bytes; in
// dump mode each pixel is its channel bytes alone with run 1. The output
// channel (out_valid_o/out_ready_i) carries one item per completed pixel or truncation:
// packed value, repeat count, start column, line_done and status (overflow
// or truncation abandon the line). The configuration channel (cfg_*) writes
// mode, channel count and line width; write it only while the block is idle.
// Timing: a result appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle; the per-byte update and the result register
// are a single stage, so a byte is taken whenever the result register is
// empty or being drained in the same cycle.
// Reset: run-coded mode, 3 channels, width 512, line state at column 0.
// Stall: while a result waits unaccepted, in_ready_o drops and the byte
// stream holds; nothing is lost.
`timescale 1ns / 1ps

module run_length_scanline_decoder #(
  parameter int unsigned MAX_LINE_WIDTH = rlsd_pkg::DEF_MAX_LINE_WIDTH,
  parameter int unsigned MAX_CHANNELS   = rlsd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rlsd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rlsd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [rlsd_pkg::BYTE_W-1:0]            data_byte_i,
  input  logic                                   stream_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [rlsd_pkg::PIXEL_W-1:0]           pixel_value_o,
  output logic [rlsd_pkg::RUN_W-1:0]             repeat_count_o,
  output logic [rlsd_pkg::START_COL_W-1:0]       start_column_o,
  output logic                                   line_done_o,
  output logic [rlsd_pkg::STATUS_W-1:0]          status_o
);
  import rlsd_pkg::*;

  localparam int unsigned COL_W    = $clog2(MAX_LINE_WIDTH + 1);
  localparam int unsigned CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned SUM_W    = ((COL_W > LWID_W) ? COL_W : LWID_W) + 1;
  localparam logic [NCH_W-1:0] MAX_NCH = NCH_W'(MAX_CHANNELS);
  localparam logic [SUM_W-1:0] MAX_WID = SUM_W'(MAX_LINE_WIDTH);

  // configuration
  logic              mode_q;
  logic [NCH_W-1:0]  nch_cfg_q;
  logic [LWID_W-1:0] wid_cfg_q;

  // line state
  logic                expect_cnt_q, expect_cnt_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [CH_IDX_W-1:0] ch_idx_q, ch_idx_d;
  logic [PIXEL_W-1:0]  acc_q, acc_d;
  logic [COL_W-1:0]    col_q, col_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic [PIXEL_W-1:0]     pix_q, pix_d;
  logic [RUN_W-1:0]       rep_q, rep_d;
  logic [START_COL_W-1:0] start_q, start_d;
  logic                   done_q, done_d;
  status_e                status_q, status_d;

  logic             in_acc;
  logic [NCH_W-1:0] nch;
  logic [SUM_W-1:0] wid;
  logic [SUM_W-1:0] wid_ext;
  logic [SUM_W-1:0] col_ext;
  logic [SUM_W-1:0] col_sum;
  logic [RUN_W-1:0] cnt;
  logic [2:0]       lane_idx;
  logic [NCH_W-1:0] idx_inc;
  logic [PIXEL_W-1:0] acc_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Clamp the registers to their legal ranges.
  always_comb begin
    if (nch_cfg_q == '0) begin
      nch = NCH_W'(1);
    end else if (nch_cfg_q > MAX_NCH) begin
      nch = MAX_NCH;
    end else begin
      nch = nch_cfg_q;
    end
    wid_ext = SUM_W'(wid_cfg_q);
    if (wid_ext == '0) begin
      wid = SUM_W'(1);
    end else if (wid_ext > MAX_WID) begin
      wid = MAX_WID;
    end else begin
      wid = wid_ext;
    end
  end

  assign col_ext  = SUM_W'(col_q);
  assign cnt      = mode_q ? run_q : RUN_W'(1);
  assign col_sum  = col_ext + SUM_W'(cnt);
  assign lane_idx = 3'(ch_idx_q);
  assign idx_inc  = NCH_W'(lane_idx) + NCH_W'(1);

  // Drop the byte into its lane; the first channel starts a fresh pixel.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (lane_idx == 3'(k)) begin
        acc_new[k*BYTE_W +: BYTE_W] = data_byte_i;
      end else if (ch_idx_q == '0) begin
        acc_new[k*BYTE_W +: BYTE_W] = '0;
      end else begin
        acc_new[k*BYTE_W +: BYTE_W] = acc_q[k*BYTE_W +: BYTE_W];
      end
    end
  end

  always_comb begin
    expect_cnt_d = expect_cnt_q;
    run_d        = run_q;
    ch_idx_d     = ch_idx_q;
    acc_d        = acc_q;
    col_d        = col_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pix_d        = pix_q;
    rep_d        = rep_q;
    start_d      = start_q;
    done_d       = done_q;
    status_d     = status_q;

    if (in_acc) begin
      priority if (stream_end_i) begin
        if (col_q != '0 || ch_idx_q != '0 || !expect_cnt_q) begin
          out_valid_d  = 1'b1;
          pix_d        = '0;
          rep_d        = '0;
          start_d      = col_ext[START_COL_W-1:0];
          done_d       = 1'b1;
          status_d     = ST_TRUNC;
          expect_cnt_d = 1'b1;
          run_d        = RUN_W'(1);
          ch_idx_d     = '0;
          acc_d        = '0;
          col_d        = '0;
        end
      end else if (mode_q && expect_cnt_q) begin
        run_d        = RUN_W'(data_byte_i) + RUN_W'(1);
        expect_cnt_d = 1'b0;
      end else if (idx_inc < nch) begin
        acc_d    = acc_new;
        ch_idx_d = CH_IDX_W'(idx_inc);
      end else begin
        // pixel complete
        ch_idx_d     = '0;
        expect_cnt_d = 1'b1;
        acc_d        = acc_new;
        out_valid_d  = 1'b1;
        pix_d        = acc_new;
        rep_d        = cnt;
        start_d      = col_ext[START_COL_W-1:0];
        if (col_sum > wid) begin
          done_d   = 1'b1;
          status_d = ST_OVERFLOW;
          run_d    = RUN_W'(1);
          acc_d    = '0;
          col_d    = '0;
        end else begin
          done_d   = (col_sum == wid);
          status_d = ST_OK;
          if (col_sum == wid) begin
            run_d = RUN_W'(1);
            acc_d = '0;
            col_d = '0;
          end else begin
            col_d = col_sum[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b1;
      nch_cfg_q    <= RST_CHANNELS;
      wid_cfg_q    <= RST_WIDTH;
      expect_cnt_q <= 1'b1;
      run_q        <= RUN_W'(1);
      ch_idx_q     <= '0;
      acc_q        <= '0;
      col_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MODE:     mode_q    <= cfg_data_i[0];
          CFG_CHANNELS: nch_cfg_q <= cfg_data_i[NCH_W-1:0];
          CFG_WIDTH:    wid_cfg_q <= cfg_data_i[LWID_W-1:0];
          default:      ;
        endcase
      end
      expect_cnt_q <= expect_cnt_d;
      run_q        <= run_d;
      ch_idx_q     <= ch_idx_d;
      acc_q        <= acc_d;
      col_q        <= col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    rep_q    <= rep_d;
    start_q  <= start_d;
    done_q   <= done_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pix_q;
  assign repeat_count_o = rep_q;
  assign start_column_o = start_q;
  assign line_done_o    = done_q;
  assign status_o       = status_q;

endmodule

FILE: sv/rlsd_checker.sv
// Port-level checks for the run-length scanline decoder, bound to the top level.
`timescale 1ns / 1ps

module rlsd_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic [rlsd_pkg::PIXEL_W-1:0]           pixel_value_o,
  input logic [rlsd_pkg::RUN_W-1:0]             repeat_count_o,
  input logic [rlsd_pkg::START_COL_W-1:0]       start_column_o,
  input logic                                   line_done_o,
  input logic [rlsd_pkg::STATUS_W-1:0]          status_o
);
  import rlsd_pkg::*;

  // A stalled item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(repeat_count_o) && $stable(start_column_o))
    else $error("result changed while stalled");

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with no result pending");

  // Errors always end the line.
  a_err_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OVERFLOW || status_o == ST_TRUNC) |-> line_done_o)
    else $error("error result without line end");

  // Truncation carries no pixel; real pixels carry a nonzero run.
  a_trunc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_TRUNC) == (repeat_count_o == '0))
      && (status_o != ST_TRUNC || pixel_value_o == '0))
    else $error("truncation payload mismatch");

endmodule

bind run_length_scanline_decoder rlsd_checker u_rlsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_value_o  (pixel_value_o),
  .repeat_count_o (repeat_count_o),
  .start_column_o (start_column_o),
  .line_done_o    (line_done_o),
  .status_o       (status_o)
);
